// ----- rtl/rational_arithmetic_unit_defines.svh -----
// Assertion helpers for the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RAU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define RAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- rtl/rau_pkg.sv -----
`timescale 1ns / 1ps
package rau_pkg;
   localparam int WIDTH = 32;
   localparam int MAGW = 2 * WIDTH + 1;
   localparam int QDEPTH = 2;

   typedef enum logic [2:0] {
      OP_ADD = 3'd0, OP_SUB = 3'd1, OP_MUL = 3'd2, OP_DIV = 3'd3,
      OP_NEG = 3'd4, OP_INC = 3'd5, OP_CMP = 3'd6, OP_NORM = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_ZERO = 2'd1, ST_OVF = 2'd2
   } status_type;

   // classified job handed from front to back
   typedef struct packed {
      op_type              op;
      logic                err;
      logic                a_neg;
      logic [WIDTH-1:0]    a_mag;
      logic [WIDTH-1:0]    b_mag;
      logic                c_neg;
      logic [WIDTH-1:0]    c_mag;
      logic [WIDTH-1:0]    d_mag;
   } job_type;

   typedef struct packed {
      logic [31:0] num;
      logic [30:0] den;
      logic        lt;
      logic        eq;
      logic        gt;
      status_type  status;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL1, S_MUL2, S_COMB, S_GCD, S_DIVN, S_DIVD, S_CHECK, S_OUT
   } state_type;
endpackage

// ----- rtl/rau_front.sv -----
`timescale 1ns / 1ps
module rau_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic [2:0]          action,
   input  logic [31:0]         lhs_num,
   input  logic [31:0]         lhs_den,
   input  logic [31:0]         rhs_num,
   input  logic [31:0]         rhs_den,
   output logic                job_valid,
   input  logic                job_take,
   output rau_pkg::job_type    job
);
   import rau_pkg::*;

   job_type             q_ff [QDEPTH];
   job_type             q_in;
   logic                wptr_ff, rptr_ff;
   logic [1:0]          cnt_ff;
   logic                wr, rd;
   logic [WIDTH-1:0]    ra, rb, rc, rdn;
   logic [WIDTH-1:0]    ma, mb, mc, md;
   logic                na, nb, nc, nd, uses_rhs;

   always_comb begin
      ra  = lhs_num[WIDTH-1:0];
      rb  = lhs_den[WIDTH-1:0];
      rc  = rhs_num[WIDTH-1:0];
      rdn = rhs_den[WIDTH-1:0];
      na = ra[WIDTH-1];  nb = rb[WIDTH-1];
      nc = rc[WIDTH-1];  nd = rdn[WIDTH-1];
      // magnitude of most negative value wraps to itself as unsigned: correct
      ma = na ? (~ra + 1'b1) : ra;
      mb = nb ? (~rb + 1'b1) : rb;
      mc = nc ? (~rc + 1'b1) : rc;
      md = nd ? (~rdn + 1'b1) : rdn;
      uses_rhs = (action[2] == 1'b0) || (op_type'(action) == OP_CMP);
      q_in.op    = op_type'(action);
      q_in.err   = (mb == '0) || (uses_rhs && md == '0)
                 || (op_type'(action) == OP_DIV && mc == '0);
      q_in.a_neg = (na ^ nb) && (ma != '0);
      q_in.a_mag = ma;
      q_in.b_mag = mb;
      q_in.c_neg = (nc ^ nd) && (mc != '0);
      q_in.c_mag = mc;
      q_in.d_mag = md;
   end

   assign full      = (cnt_ff == 2'(QDEPTH));
   assign job_valid = (cnt_ff != 2'd0);
   assign wr  = push && !full;
   assign rd  = job_take && job_valid;
   assign job = q_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (wr) q_ff[wptr_ff] <= q_in;
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (wr) wptr_ff <= ~wptr_ff;
         if (rd) rptr_ff <= ~rptr_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
   end
endmodule

// ----- rtl/rau_back.sv -----
`timescale 1ns / 1ps
module rau_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   output logic                job_take,
   input  rau_pkg::job_type    job,
   output logic                rsp_valid,
   input  logic                rsp_take,
   output rau_pkg::rsp_type    rsp
);
   import rau_pkg::*;

   state_type            state_ff, state_in;
   job_type              job_ff;
   logic [2*WIDTH-1:0]   p1_ff, p2_ff;
   logic                 nneg_ff;
   logic [MAGW-1:0]      n_ff, m_ff;
   // gcd: binary, on copies
   logic [MAGW-1:0]      gu_ff, gv_ff;
   logic [6:0]           gk_ff;
   // restoring divider
   logic [MAGW-1:0]      dq_ff, dr_ff, dd_ff, rn_ff;
   logic [6:0]           dc_ff;
   // result under construction; rsp_ff holds the word on the port
   rsp_type              res_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   logic [WIDTH-1:0]     mx_a, mx_b;
   logic [2*WIDTH-1:0]   prod;
   logic [MAGW-1:0]      s1, s2, diff;
   logic                 s1n, s2n, sn;
   logic [MAGW-1:0]      ssum;
   logic [MAGW:0]        trial;
   logic [MAGW-1:0]      rem_sh;
   logic [MAGW-1:0]      lim;
   logic                 ovf;

   assign job_take  = (state_ff == S_IDLE) && job_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign lim       = MAGW'(1) << (WIDTH - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (job_valid) state_in = S_MUL1;
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_COMB;
         S_COMB:  state_in = (job_ff.err || job_ff.op == OP_CMP) ? S_OUT : S_GCD;
         S_GCD:   if (gv_ff == '0) state_in = S_DIVN;
         S_DIVN:  if (dc_ff == '0) state_in = S_DIVD;
         S_DIVD:  if (dc_ff == '0) state_in = S_CHECK;
         S_CHECK: state_in = S_OUT;
         S_OUT:   if (!rsp_valid_ff || rsp_take) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // one multiplier, three uses: a*d, then b*c (a*c for mul), then b*d
   always_comb begin
      unique case (state_ff)
         S_MUL1:  begin mx_a = job_ff.a_mag; mx_b = job_ff.d_mag; end
         S_MUL2:  begin
            mx_a = (job_ff.op == OP_MUL) ? job_ff.a_mag : job_ff.b_mag;
            mx_b = job_ff.c_mag;
         end
         default: begin
            mx_a = job_ff.b_mag;
            mx_b = job_ff.d_mag;
         end
      endcase
      prod = {{WIDTH{1'b0}}, mx_a} * {{WIDTH{1'b0}}, mx_b};
   end

   // signed add of p1 (sign a) and p2 (sign c, flipped for sub); for inc, a plus b
   always_comb begin
      s1  = MAGW'(p1_ff);
      s2  = MAGW'(p2_ff);
      s1n = job_ff.a_neg;
      s2n = job_ff.c_neg ^ (job_ff.op == OP_SUB);
      if (job_ff.op == OP_INC) begin
         s1 = MAGW'(job_ff.a_mag);
         s2 = MAGW'(job_ff.b_mag);
         s2n = 1'b0;
      end
      diff = s1 - s2;
      if (s1n == s2n) begin
         ssum = s1 + s2; sn = s1n;
      end else if (s1 >= s2) begin
         ssum = diff; sn = s1n;
      end else begin
         ssum = s2 - s1; sn = s2n;
      end
      if (ssum == '0) sn = 1'b0;
   end

   always_comb begin
      rem_sh = {dr_ff[MAGW-2:0], dq_ff[MAGW-1]};
      trial  = {1'b0, rem_sh} - {1'b0, dd_ff};
      ovf = (m_ff > lim - 1'b1) || (nneg_ff ? (rn_ff > lim) : (rn_ff > lim - 1'b1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_OUT) || (rsp_valid_ff && !rsp_take);
      end
      unique case (state_ff)
         S_IDLE: if (job_valid) job_ff <= job;
         S_MUL1: p1_ff <= prod;
         S_MUL2: p2_ff <= prod;
         S_COMB: begin
            unique case (job_ff.op) inside
               OP_ADD, OP_SUB, OP_INC: begin n_ff <= ssum; nneg_ff <= sn; end
               OP_MUL: begin
                  n_ff <= MAGW'(p2_ff);
                  nneg_ff <= (job_ff.a_neg ^ job_ff.c_neg) && (p2_ff != '0);
               end
               OP_DIV: begin
                  n_ff <= MAGW'(p1_ff);
                  nneg_ff <= (job_ff.a_neg ^ job_ff.c_neg) && (p1_ff != '0);
               end
               OP_NEG: begin
                  n_ff <= MAGW'(job_ff.a_mag);
                  nneg_ff <= !job_ff.a_neg && (job_ff.a_mag != '0);
               end
               default: begin n_ff <= MAGW'(job_ff.a_mag); nneg_ff <= job_ff.a_neg; end
            endcase
            unique case (job_ff.op) inside
               OP_ADD, OP_SUB, OP_MUL: m_ff <= MAGW'(prod);
               OP_DIV: m_ff <= MAGW'(p2_ff);
               default: m_ff <= MAGW'(job_ff.b_mag);
            endcase
            gk_ff <= '0;
            res_ff.num <= '0;
            res_ff.den <= 31'd1;
            res_ff.lt <= 1'b0;
            res_ff.eq <= 1'b0;
            res_ff.gt <= 1'b0;
            res_ff.status <= job_ff.err ? ST_ZERO : ST_OK;
            if (!job_ff.err && job_ff.op == OP_CMP) begin
               // compare a*d (p1, sign a) with c*b (p2, sign c)
               if (job_ff.a_neg != job_ff.c_neg) begin
                  res_ff.lt <= job_ff.a_neg;
                  res_ff.gt <= !job_ff.a_neg;
               end else if (p1_ff == p2_ff) begin
                  res_ff.eq <= 1'b1;
               end else begin
                  res_ff.lt <= job_ff.a_neg ^ (p1_ff < p2_ff);
                  res_ff.gt <= !(job_ff.a_neg ^ (p1_ff < p2_ff));
               end
            end
         end
         S_GCD: begin
            if (gv_ff == '0) begin
               dq_ff <= n_ff;
               dr_ff <= '0;
               dd_ff <= (gu_ff << gk_ff) == '0 ? MAGW'(1) : (gu_ff << gk_ff);
               dc_ff <= 7'(MAGW - 1);
            end else if (gu_ff == '0) begin
               // gcd(0, v) = v
               gu_ff <= gv_ff; gv_ff <= '0;
            end else if (!gu_ff[0] && !gv_ff[0]) begin
               gu_ff <= gu_ff >> 1; gv_ff <= gv_ff >> 1; gk_ff <= gk_ff + 7'd1;
            end else if (!gu_ff[0]) begin
               gu_ff <= gu_ff >> 1;
            end else if (!gv_ff[0]) begin
               gv_ff <= gv_ff >> 1;
            end else if (gu_ff > gv_ff) begin
               gu_ff <= gv_ff; gv_ff <= (gu_ff - gv_ff) >> 1;
            end else begin
               gv_ff <= (gv_ff - gu_ff) >> 1;
            end
         end
         S_DIVN, S_DIVD: begin
            if (dc_ff != '0) begin
               dr_ff <= trial[MAGW] ? rem_sh : trial[MAGW-1:0];
               dq_ff <= {dq_ff[MAGW-2:0], !trial[MAGW]};
               dc_ff <= dc_ff - 7'd1;
            end else if (state_ff == S_DIVN) begin
               rn_ff <= {dq_ff[MAGW-2:0], !trial[MAGW]};
               dq_ff <= m_ff;
               dr_ff <= '0;
               dc_ff <= 7'(MAGW - 1);
            end else begin
               m_ff <= {dq_ff[MAGW-2:0], !trial[MAGW]};
            end
         end
         S_CHECK: begin
            if (rn_ff == '0) nneg_ff <= 1'b0;
            if (ovf && !(rn_ff == '0 && m_ff <= lim - 1'b1)) begin
               res_ff.status <= ST_OVF;
            end else begin
               res_ff.num <= (nneg_ff && rn_ff != '0) ? 32'(~rn_ff + 1'b1) : 32'(rn_ff);
               res_ff.den <= 31'(m_ff);
            end
         end
         S_OUT: if (!rsp_valid_ff || rsp_take) rsp_ff <= res_ff;
         default: ;
      endcase
      // gcd operands load as combine finishes
      if (state_ff == S_COMB) begin
         unique case (job_ff.op) inside
            OP_ADD, OP_SUB, OP_INC: gu_ff <= ssum;
            OP_MUL: gu_ff <= MAGW'(p2_ff);
            OP_DIV: gu_ff <= MAGW'(p1_ff);
            default: gu_ff <= MAGW'(job_ff.a_mag);
         endcase
         unique case (job_ff.op) inside
            OP_ADD, OP_SUB, OP_MUL: gv_ff <= MAGW'(prod);
            OP_DIV: gv_ff <= MAGW'(p2_ff);
            default: gv_ff <= MAGW'(job_ff.b_mag);
         endcase
      end
   end
endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake           words
// req_      in         push / full         action, lhs_num, lhs_den, rhs_num, rhs_den
// rsp_      out        empty / pop         res_num, res_den, flags, status
// A word passes S_MUL1, S_MUL2, S_COMB, S_GCD, S_DIVN, S_DIVD, S_CHECK, S_OUT;
// compare and zero-denominator words go from S_COMB straight to S_OUT.
// The latency is set by the binary gcd loop and the one-bit restoring divider.
// Reset is synchronous, active high, clears the queue and the sequencer.
// A two-entry queue lets the front take words while the back computes or the
// result waits for pop.
module rational_arithmetic_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic [2:0]   req_action,
   input  logic [31:0]  req_lhs_num,
   input  logic [31:0]  req_lhs_den,
   input  logic [31:0]  req_rhs_num,
   input  logic [31:0]  req_rhs_den,
   output logic         empty,
   input  logic         pop,
   output logic [31:0]  rsp_res_num,
   output logic [30:0]  rsp_res_den,
   output logic         rsp_is_less,
   output logic         rsp_is_equal,
   output logic         rsp_is_greater,
   output logic [1:0]   rsp_status
);
   import rau_pkg::*;
`include "rational_arithmetic_unit_defines.svh"

   logic    job_valid, job_take, rsp_valid;
   job_type job;
   rsp_type rsp;

   rau_front u_front (
      .clock, .reset, .push, .full,
      .action(req_action), .lhs_num(req_lhs_num), .lhs_den(req_lhs_den),
      .rhs_num(req_rhs_num), .rhs_den(req_rhs_den),
      .job_valid, .job_take, .job
   );

   rau_back u_back (
      .clock, .reset, .job_valid, .job_take, .job,
      .rsp_valid, .rsp_take(pop), .rsp
   );

   assign empty          = !rsp_valid;
   assign rsp_res_num    = rsp.num;
   assign rsp_res_den    = rsp.den;
   assign rsp_is_less    = rsp.lt;
   assign rsp_is_equal   = rsp.eq;
   assign rsp_is_greater = rsp.gt;
   assign rsp_status     = rsp.status;

   `RAU_ASSERT_IMPL(a_flags_onehot0, clock, reset, !empty,
      $onehot0({rsp_is_less, rsp_is_equal, rsp_is_greater}), "compare flags not exclusive")
   `RAU_ASSERT_IMPL(a_den_nonzero, clock, reset, !empty, rsp_res_den != '0,
      "zero denominator delivered")
   `RAU_ASSERT_NEXT(a_hold, clock, reset, !empty && !pop,
      !empty && $stable(rsp_res_num), "result dropped while stalled")
endmodule

// ----- tb/tb_rational_arithmetic_unit.sv -----
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
   import rau_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        push = 0;
   logic        pop = 0;
   logic        full, empty;
   logic [2:0]  req_action = '0;
   logic [31:0] req_lhs_num = '0, req_lhs_den = 32'd1;
   logic [31:0] req_rhs_num = '0, req_rhs_den = 32'd1;
   logic [31:0] rsp_res_num;
   logic [30:0] rsp_res_den;
   logic        rsp_is_less, rsp_is_equal, rsp_is_greater;
   logic [1:0]  rsp_status;

   rational_arithmetic_unit DUT (.*);

   always #6 clock = ~clock;

   typedef struct {
      op_type      op;
      logic [31:0] an, ad, bn, bd;
   } operands_type;

   typedef struct {
      logic [31:0] num;
      logic [30:0] den;
      logic        lt, eq, gt;
      status_type  status;
   } fraction_type;

   typedef struct {
      operands_type ops;
      logic         known;
      fraction_type res;
   } row_type;

   fraction_type pending_q[$];
   int        errors = 0;
   int        words_out = 0;
   int        n_ovf = 0, n_zero = 0, n_cmp = 0;
   logic      quiet = 0;

   // sign plus 64-bit magnitude, with a spare bit for sums
   typedef struct {
      logic        neg;
      logic [64:0] mag;
   } smag_type;

   function automatic smag_type split(logic [31:0] v);
      smag_type r;
      r.neg = v[31];
      r.mag = v[31] ? 65'(-$signed({1'b1, v})) : 65'(v);
      return r;
   endfunction

   function automatic smag_type mul_s(smag_type a, smag_type b);
      smag_type r;
      r.mag = a.mag * b.mag;
      r.neg = (a.neg != b.neg) && r.mag != 0;
      return r;
   endfunction

   function automatic smag_type flip(smag_type a);
      if (a.mag != 0) a.neg = ~a.neg;
      return a;
   endfunction

   function automatic smag_type add_s(smag_type a, smag_type b);
      smag_type r;
      if (a.neg == b.neg) begin
         r.mag = a.mag + b.mag; r.neg = a.neg;
      end else if (a.mag >= b.mag) begin
         r.mag = a.mag - b.mag; r.neg = a.neg;
      end else begin
         r.mag = b.mag - a.mag; r.neg = b.neg;
      end
      if (r.mag == 0) r.neg = 0;
      return r;
   endfunction

   function automatic fraction_type reduce_fraction(operands_type o);
      fraction_type f;
      smag_type a, b, c, d, n, m;
      logic [64:0] g, x, y, t, rn, rd;
      logic uses_rhs;
      int cmp;
      f = '{num: 0, den: 1, lt: 0, eq: 0, gt: 0, status: ST_OK};
      a = split(o.an); b = split(o.ad); c = split(o.bn); d = split(o.bd);
      uses_rhs = o.op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP};
      if (b.mag == 0 || (uses_rhs && d.mag == 0) || (o.op == OP_DIV && c.mag == 0)) begin
         f.status = ST_ZERO;
         return f;
      end
      if (b.neg) begin a = flip(a); b.neg = 0; end
      if (d.neg) begin c = flip(c); d.neg = 0; end
      case (o.op)
         OP_ADD:  begin n = add_s(mul_s(a, d), mul_s(b, c)); m = mul_s(b, d); end
         OP_SUB:  begin n = add_s(mul_s(a, d), flip(mul_s(b, c))); m = mul_s(b, d); end
         OP_MUL:  begin n = mul_s(a, c); m = mul_s(b, d); end
         OP_DIV:  begin
            n = mul_s(a, d); m = mul_s(b, c);
            if (m.neg) begin n = flip(n); m.neg = 0; end
         end
         OP_NEG:  begin n = flip(a); m = b; end
         OP_INC:  begin n = add_s(a, b); m = b; end
         OP_CMP:  begin
            n = add_s(mul_s(a, d), flip(mul_s(c, b)));
            cmp = n.mag == 0 ? 0 : (n.neg ? -1 : 1);
            f.lt = cmp < 0; f.eq = cmp == 0; f.gt = cmp > 0;
            return f;
         end
         default: begin n = a; m = b; end
      endcase
      x = n.mag; y = m.mag;
      while (y != 0) begin t = x % y; x = y; y = t; end
      g = x == 0 ? 1 : x;
      rn = n.mag / g; rd = m.mag / g;
      if (rn == 0) n.neg = 0;
      if (rd > 65'h7FFF_FFFF || (n.neg ? rn > 65'h8000_0000 : rn > 65'h7FFF_FFFF)) begin
         f.status = ST_OVF;
         return f;
      end
      f.num = n.neg ? 32'(-rn) : rn[31:0];
      f.den = rd[30:0];
      return f;
   endfunction

   function automatic logic [31:0] pick();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 40)) - 20);
         2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         3: return 32'($signed($urandom_range(0, 2000)) - 1000);
         4: return $urandom & 32'h0000_FFFF;
         default: return 32'($signed($urandom_range(0, 10)) - 5);
      endcase
   endfunction

   // push stays high after the word goes in; idling or the caller drops it
   task automatic send(operands_type o);
      fraction_type f;
      f = reduce_fraction(o);
      while (!quiet && $urandom_range(0, 99) < 15) begin
         push <= 0;
         @(posedge clock);
      end
      push <= 1;
      req_action <= o.op;
      req_lhs_num <= o.an; req_lhs_den <= o.ad;
      req_rhs_num <= o.bn; req_rhs_den <= o.bd;
      @(posedge clock);
      while (full) @(posedge clock);
      pending_q.push_back(f);
   endtask

   // result side
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         fraction_type e;
         if (pending_q.size() == 0) begin
            $error("result word with nothing pending");
            errors++;
         end else begin
            e = pending_q.pop_front();
            words_out++;
            if (e.status == ST_OVF) n_ovf++;
            if (e.status == ST_ZERO) n_zero++;
            if (e.lt | e.eq | e.gt) n_cmp++;
            if (rsp_res_num !== e.num) begin
               $error("res_num exp %h got %h", e.num, rsp_res_num); errors++;
            end
            if (rsp_res_den !== e.den) begin
               $error("res_den exp %h got %h", e.den, rsp_res_den); errors++;
            end
            if (rsp_is_less !== e.lt) begin
               $error("is_less exp %b got %b", e.lt, rsp_is_less); errors++;
            end
            if (rsp_is_equal !== e.eq) begin
               $error("is_equal exp %b got %b", e.eq, rsp_is_equal); errors++;
            end
            if (rsp_is_greater !== e.gt) begin
               $error("is_greater exp %b got %b", e.gt, rsp_is_greater); errors++;
            end
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); errors++;
            end
         end
      end
      pop <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 15);
   end

   initial begin
      #40_000_000;
      $display("rational_arithmetic_unit regression: fail");
      $finish;
   end

   initial begin
      row_type rows[$];
      row_type r;
      operands_type o;
      fraction_type f;
      int k;
      // directed rows; known results typed in where obvious
      rows = '{
         '{'{OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3}, 1, '{5, 6, 0, 0, 0, ST_OK}},
         '{'{OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2}, 1, '{0, 1, 0, 0, 0, ST_OK}},
         '{'{OP_MUL, 32'd2, 32'd3, 32'd3, 32'd4}, 1, '{1, 2, 0, 0, 0, ST_OK}},
         '{'{OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5}, 1, '{0, 1, 0, 0, 0, ST_ZERO}},
         '{'{OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1}, 1, '{0, 1, 0, 0, 0, ST_ZERO}},
         '{'{OP_ADD, 32'd1, 32'd1, 32'd1, 32'd0}, 1, '{0, 1, 0, 0, 0, ST_ZERO}},
         '{'{OP_NEG, 32'd3, 32'd6, 32'd9, 32'd0}, 1, '{32'hFFFF_FFFF, 2, 0, 0, 0, ST_OK}},
         '{'{OP_INC, 32'd1, 32'd2, 32'd0, 32'd0}, 1, '{3, 2, 0, 0, 0, ST_OK}},
         '{'{OP_NORM, 32'd4, -32'sd8, 32'd0, 32'd0}, 1, '{32'hFFFF_FFFF, 2, 0, 0, 0, ST_OK}},
         '{'{OP_NORM, 32'd0, 32'd7, 32'd0, 32'd0}, 1, '{0, 1, 0, 0, 0, ST_OK}},
         '{'{OP_CMP, 32'd1, 32'd2, 32'd2, 32'd4}, 1, '{0, 1, 0, 1, 0, ST_OK}},
         '{'{OP_CMP, 32'd1, 32'd3, 32'd1, 32'd2}, 1, '{0, 1, 1, 0, 0, ST_OK}},
         '{'{OP_CMP, 32'd1, 32'd2, -32'sd1, 32'd2}, 1, '{0, 1, 0, 0, 1, ST_OK}},
         '{'{OP_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd0}, 1, '{0, 1, 0, 0, 0, ST_OVF}},
         '{'{OP_NORM, 32'h8000_0000, 32'd1, 32'd0, 32'd0}, 1,
           '{32'h8000_0000, 1, 0, 0, 0, ST_OK}},
         '{'{OP_NORM, 32'd1, 32'h8000_0000, 32'd0, 32'd0}, 1, '{0, 1, 0, 0, 0, ST_OVF}},
         '{'{OP_INC, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'd0}, 1, '{0, 1, 0, 0, 0, ST_OVF}},
         '{'{OP_MUL, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1}, 0, '{0, 1, 0, 0, 0, ST_OK}},
         '{'{OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000}, 0,
           '{0, 1, 0, 0, 0, ST_OK}},
         '{'{OP_DIV, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 0,
           '{0, 1, 0, 0, 0, ST_OK}},
         '{'{OP_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 0,
           '{0, 1, 0, 0, 0, ST_OK}},
         '{'{OP_CMP, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 0,
           '{0, 1, 0, 0, 0, ST_OK}}
      };
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (rows[i]) begin
         r = rows[i];
         f = reduce_fraction(r.ops);
         if (r.known && f != r.res) begin
            $error("directed row %0d disagrees with hand value", i);
            errors++;
         end
         send(r.ops);
      end
      for (k = 0; k < 1800; k++) begin
         quiet = (k >= 600 && k < 800);
         if (k == 1000) begin
            // drain completely before continuing
            push <= 0;
            while (pending_q.size() != 0) @(posedge clock);
         end
         o.op = op_type'($urandom_range(0, 7));
         o.an = pick(); o.ad = pick(); o.bn = pick(); o.bd = pick();
         send(o);
      end
      push <= 0;
      quiet = 0;
      k = 0;
      while (pending_q.size() != 0 && k < 100000) begin
         @(posedge clock);
         k++;
      end
      repeat (300) @(posedge clock);
      $display("covered %0d words: %0d overflow, %0d zero-denominator, %0d compares",
               words_out, n_ovf, n_zero, n_cmp);
      if (errors == 0 && pending_q.size() == 0)
         $display("rational_arithmetic_unit regression: pass");
      else
         $display("rational_arithmetic_unit regression: fail");
      $finish;
   end
endmodule
